### rtl/crc_pkg.sv
// Package: shared constants and types for the CRC generator/checker.
`timescale 1ns / 1ps
`default_nettype none
package crc_pkg;

  localparam int MAX_DEGREE_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int POLY_W = 32;
  localparam int DEGREE_W = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [POLY_W-1:0] POLY_RESET = 32'h0000_1021;
  localparam logic [DEGREE_W-1:0] DEGREE_RESET = 6'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_POLY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd2;

  localparam logic MODE_GENERATE = 1'b0;
  localparam logic MODE_CHECK = 1'b1;

  typedef enum logic [1:0] {
    KIND_ECHO,
    KIND_GEN_LAST,
    KIND_CHECK
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  bit_val;
    logic  ok;
  } cmd_t;

endpackage
`default_nettype wire

### rtl/crc_ifs.sv
// Interfaces: input bit channel and result channel.
`timescale 1ns / 1ps
`default_nettype none
interface crc_in_if;
  logic valid;
  logic ready;
  logic msg_bit;
  logic last_bit;
  modport source (output valid, msg_bit, last_bit, input ready);
  modport sink (input valid, msg_bit, last_bit, output ready);
endinterface

interface crc_out_if;
  logic valid;
  logic ready;
  logic out_bit;
  logic is_remainder;
  logic out_last;
  logic check_ok;
  modport source (output valid, out_bit, is_remainder, out_last, check_ok, input ready);
  modport sink (input valid, out_bit, is_remainder, out_last, check_ok, output ready);
endinterface
`default_nettype wire

### rtl/crc_front.sv
// Front end: config registers, one division step per accepted bit, command push.
`timescale 1ns / 1ps
`default_nettype none
module crc_front
  import crc_pkg::*;
#(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  crc_in_if.sink                     bits_in,
  input  wire logic                  full,
  output logic                       push,
  output cmd_t                       push_cmd,
  output logic [MAX_DEGREE-1:0]      push_rem,
  output logic [MAX_DEGREE-1:0]      push_ptr
);

  logic [POLY_W-1:0]     poly_low;
  logic [DEGREE_W-1:0]   degree;
  logic                  mode;
  logic [MAX_DEGREE-1:0] remainder;

  logic [6:0]            deg_eff;
  logic [63:0]           poly_ext;
  logic [MAX_DEGREE-1:0] mask;
  logic [MAX_DEGREE-1:0] topsel;
  logic [MAX_DEGREE-1:0] gen;
  logic [MAX_DEGREE-1:0] rem_m;
  logic [MAX_DEGREE-1:0] rem_next;
  logic                  top;
  logic                  accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      poly_low <= POLY_RESET;
      degree   <= DEGREE_RESET;
      mode     <= MODE_GENERATE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POLY:   poly_low <= cfg_data[POLY_W-1:0];
        CFG_DEGREE: degree   <= cfg_data[DEGREE_W-1:0];
        CFG_MODE:   mode     <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  // clamp degree into 1..MAX_DEGREE
  assign deg_eff = (degree == '0) ? 7'd1 :
                   ({1'b0, degree} > 7'(MAX_DEGREE)) ? 7'(MAX_DEGREE) : {1'b0, degree};
  assign poly_ext = {32'b0, poly_low};

  always_comb begin
    for (int i = 0; i < MAX_DEGREE; i++) begin
      mask[i]   = (7'(i) < deg_eff);
      topsel[i] = (7'(i + 1) == deg_eff);
    end
  end

  assign gen   = poly_ext[MAX_DEGREE-1:0] & mask;
  assign rem_m = remainder & mask;
  assign top   = |(rem_m & topsel);

  always_comb begin
    if (mode == MODE_GENERATE) begin
      // augmented division: feedback is top bit xor incoming bit
      rem_next = ((rem_m << 1) & mask) ^ ((top ^ bits_in.msg_bit) ? gen : '0);
    end else begin
      rem_next = (((rem_m << 1) | MAX_DEGREE'(bits_in.msg_bit)) & mask) ^ (top ? gen : '0);
    end
  end

  assign bits_in.ready = !full;
  assign accept = bits_in.valid && !full;
  assign push = accept && ((mode == MODE_GENERATE) || bits_in.last_bit);

  always_comb begin
    push_cmd.kind    = (mode == MODE_CHECK) ? KIND_CHECK :
                       bits_in.last_bit ? KIND_GEN_LAST : KIND_ECHO;
    push_cmd.bit_val = bits_in.msg_bit;
    push_cmd.ok      = (rem_next == '0);
  end

  assign push_rem = rem_next;
  assign push_ptr = topsel;

  always_ff @(posedge clk) begin
    if (rst) begin
      remainder <= '0;
    end else if (accept) begin
      remainder <= bits_in.last_bit ? '0 : rem_next;
    end
  end

endmodule
`default_nettype wire

### rtl/crc_queue.sv
// Small FIFO of commands between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module crc_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

### rtl/crc_back.sv
// Back end: turns commands into result transactions, drains remainders MSB first.
`timescale 1ns / 1ps
`default_nettype none
module crc_back
  import crc_pkg::*;
#(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  empty,
  input  wire cmd_t                  cmd,
  input  wire logic [MAX_DEGREE-1:0] cmd_rem,
  input  wire logic [MAX_DEGREE-1:0] cmd_ptr,
  output logic                       pop,
  crc_out_if.source                  results
);

  logic                  draining;
  logic [MAX_DEGREE-1:0] rem;
  logic [MAX_DEGREE-1:0] ptr;

  logic slot_free;
  logic load;
  logic drain_step;
  logic start_drain;
  logic nxt_bit, nxt_rem, nxt_last, nxt_ok;

  assign slot_free = !results.valid || results.ready;

  always_comb begin
    pop         = 1'b0;
    load        = 1'b0;
    drain_step  = 1'b0;
    start_drain = 1'b0;
    nxt_bit     = 1'b0;
    nxt_rem     = 1'b0;
    nxt_last    = 1'b0;
    nxt_ok      = 1'b0;
    if (slot_free) begin
      if (draining) begin
        load       = 1'b1;
        drain_step = 1'b1;
        nxt_bit    = |(rem & ptr);
        nxt_rem    = 1'b1;
        nxt_last   = ptr[0];
      end else if (!empty) begin
        pop  = 1'b1;
        load = 1'b1;
        unique case (cmd.kind)
          KIND_ECHO: begin
            nxt_bit = cmd.bit_val;
          end
          KIND_GEN_LAST: begin
            nxt_bit     = cmd.bit_val;
            start_drain = 1'b1;
          end
          KIND_CHECK: begin
            nxt_last = 1'b1;
            nxt_ok   = cmd.ok;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draining      <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (start_drain) begin
        draining <= 1'b1;
      end else if (drain_step && ptr[0]) begin
        draining <= 1'b0;
      end
      if (load) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_drain) begin
      rem <= cmd_rem;
      ptr <= cmd_ptr;
    end else if (drain_step) begin
      ptr <= ptr >> 1;
    end
    if (load) begin
      results.out_bit      <= nxt_bit;
      results.is_remainder <= nxt_rem;
      results.out_last     <= nxt_last;
      results.check_ok     <= nxt_ok;
    end
  end

endmodule
`default_nettype wire

### rtl/crc_mod2_generate_check.sv
// Top level: bit-serial CRC generator/checker with configurable generator polynomial.
//
// Channels: bits_in carries msg_bit/last_bit (MSB first), results carries
// out_bit/is_remainder/out_last/check_ok; both are valid/ready, a transaction
// completes when valid and ready are high at a clock edge. Config is a write
// port (cfg_we, cfg_index, cfg_data): 0 poly_low, 1 degree, 2 mode; write only
// while idle.
// Throughput: one input bit per cycle while the queue has room. The front end does
// one division step per bit and pushes a command (in check mode only for the last
// bit) into a QUEUE_DEPTH-entry queue; the back end emits one result per cycle while
// the receiver is ready. In generate mode the last bit yields d+1 results (echo plus
// d remainder bits), so input stalls once the queue fills behind a remainder drain.
// Check mode emits one result per message. Results are registered after the queue.
// Reset: config returns to 0x1021 / degree 16 / generate, remainder and queue
// clear, no result valid. A stalled receiver holds the output register; the
// queue absorbs up to QUEUE_DEPTH commands before bits_in.ready drops.
`timescale 1ns / 1ps
`default_nettype none
module crc_mod2_generate_check
  import crc_pkg::*;
#(
  parameter int MAX_DEGREE  = MAX_DEGREE_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  crc_in_if.sink                     bits_in,
  crc_out_if.source                  results
);

  localparam int QW = $bits(cmd_t) + 2 * MAX_DEGREE;

  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_empty;
  cmd_t                  push_cmd;
  cmd_t                  pop_cmd;
  logic [MAX_DEGREE-1:0] push_rem;
  logic [MAX_DEGREE-1:0] push_ptr;
  logic [MAX_DEGREE-1:0] pop_rem;
  logic [MAX_DEGREE-1:0] pop_ptr;
  logic [QW-1:0]         pop_data;

  crc_front #(.MAX_DEGREE(MAX_DEGREE)) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .bits_in  (bits_in),
    .full     (q_full),
    .push     (q_push),
    .push_cmd (push_cmd),
    .push_rem (push_rem),
    .push_ptr (push_ptr)
  );

  crc_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data({push_cmd, push_rem, push_ptr}),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (pop_data),
    .empty    (q_empty)
  );

  assign {pop_cmd, pop_rem, pop_ptr} = pop_data;

  crc_back #(.MAX_DEGREE(MAX_DEGREE)) u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (q_empty),
    .cmd    (pop_cmd),
    .cmd_rem(pop_rem),
    .cmd_ptr(pop_ptr),
    .pop    (q_pop),
    .results(results)
  );

  // queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("command queue overflow");

  // queue never popped while empty
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("command queue underflow");

  // a check verdict always closes its message and is never a remainder bit
  a_check_shape: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.check_ok) |-> (results.out_last && !results.is_remainder))
    else $error("check verdict with wrong flags");

  // no result is offered right after reset
  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !results.valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire

### test/crc_mod2_generate_check_tb.sv
// Self-checking testbench for the bit-serial CRC generator/checker.
`timescale 1ns / 1ps
module crc_mod2_generate_check_tb;
  import crc_pkg::*;

  localparam int MAX_DEGREE = MAX_DEGREE_DEF;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic out_bit;
    logic is_remainder;
    logic out_last;
    logic check_ok;
  } crc_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  crc_in_if bits_ch ();
  crc_out_if res_ch ();

  crc_mod2_generate_check i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .bits_in(bits_ch),
    .results(res_ch)
  );

  // predictor copy of the configuration and the running remainder
  logic [POLY_W-1:0] cfg_poly;
  logic [DEGREE_W-1:0] cfg_degree;
  logic cfg_mode;
  logic [31:0] crc_rem;

  crc_result_t expected_results[$];

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_cycles = 0;
  int mismatch_count = 0;
  int bits_sent = 0;
  int messages_sent = 0;
  int results_checked = 0;
  int verdicts_seen = 0;
  int verdicts_ok = 0;
  int stall_cycles = 0;

  always #10 clk = ~clk;

  function automatic int unsigned eff_degree(logic [DEGREE_W-1:0] dg);
    if (dg == 0) return 1;
    if (dg > MAX_DEGREE) return MAX_DEGREE;
    return dg;
  endfunction

  // codeword that is an exact multiple of the current generator
  function automatic logic [63:0] multiple_of_generator(logic [63:0] m, int mlen);
    int unsigned d;
    logic [63:0] gen;
    logic [63:0] prod;
    d = eff_degree(cfg_degree);
    gen = (64'd1 << d) | ({32'h0, cfg_poly} & ((64'd1 << d) - 64'd1));
    prod = '0;
    for (int i = 0; i < mlen; i++) begin
      if (m[i]) prod ^= gen << i;
    end
    return prod;
  endfunction

  task automatic crc_predict(logic msg, logic last);
    int unsigned d;
    int i;
    logic [63:0] mask;
    logic [63:0] g;
    logic [63:0] r;
    logic top;
    d = eff_degree(cfg_degree);
    mask = (64'd1 << d) - 64'd1;
    g = {32'h0, cfg_poly} & mask;
    r = {32'h0, crc_rem} & mask;
    top = r[d-1];
    if (cfg_mode == MODE_GENERATE) begin
      // augmented division, remainder of M(x)*x^d
      r = (r << 1) & mask;
      if (top ^ msg) r ^= g;
      expected_results.push_back(crc_result_t'{msg, 1'b0, 1'b0, 1'b0});
      if (last) begin
        for (i = d - 1; i >= 0; i--)
          expected_results.push_back(crc_result_t'{r[i], 1'b1, i == 0, 1'b0});
        r = '0;
      end
    end else begin
      r = ((r << 1) | 64'(msg)) & mask;
      if (top) r ^= g;
      if (last) begin
        expected_results.push_back(crc_result_t'{1'b0, 1'b0, 1'b1, r == 0});
        r = '0;
      end
    end
    crc_rem = r[31:0];
  endtask

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("tb: mismatch: %0s", msg);
  endtask

  task automatic check_result();
    crc_result_t exp_r;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected at %0t", $realtime));
      return;
    end
    exp_r = expected_results.pop_front();
    results_checked++;
    if (res_ch.out_last && !res_ch.is_remainder && exp_r.out_last && !exp_r.out_bit) begin
      verdicts_seen++;
      if (exp_r.check_ok) verdicts_ok++;
    end
    if (res_ch.out_bit !== exp_r.out_bit)
      report_mismatch($sformatf("result %0d out_bit %b, want %b", results_checked,
                                res_ch.out_bit, exp_r.out_bit));
    if (res_ch.is_remainder !== exp_r.is_remainder)
      report_mismatch($sformatf("result %0d is_remainder %b, want %b", results_checked,
                                res_ch.is_remainder, exp_r.is_remainder));
    if (res_ch.out_last !== exp_r.out_last)
      report_mismatch($sformatf("result %0d out_last %b, want %b", results_checked,
                                res_ch.out_last, exp_r.out_last));
    if (res_ch.check_ok !== exp_r.check_ok)
      report_mismatch($sformatf("result %0d check_ok %b, want %b", results_checked,
                                res_ch.check_ok, exp_r.check_ok));
  endtask

  // result side: random stalls plus an optional long hold-off
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) check_result();
      if (hold_cycles > 0) begin
        res_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if ((bits_ch.valid && bits_ch.ready) || (res_ch.valid && res_ch.ready) || rst)
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: watchdog expired, %0d results still expected",
                 expected_results.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  // valid is left high after a transaction; wait_drained drops it, as does the next call when it idles first
  task automatic send_bit(logic msg, logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      bits_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    bits_ch.valid <= 1'b1;
    bits_ch.msg_bit <= msg;
    bits_ch.last_bit <= last;
    do @(posedge clk); while (!bits_ch.ready);
    crc_predict(msg, last);
    bits_sent++;
    if (last) messages_sent++;
  endtask

  task automatic send_message(logic [63:0] word, int len);
    for (int i = len - 1; i >= 0; i--) send_bit(word[i], i == 0);
  endtask

  // non-last check-mode bits give no result, so also settle after the expected results are out
  task automatic wait_drained();
    bits_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_POLY: cfg_poly = data;
      CFG_DEGREE: cfg_degree = data[DEGREE_W-1:0];
      CFG_MODE: cfg_mode = data[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_reset_config();
    // short messages against the CCITT generator left by reset
    send_message(64'b1, 1);
    send_message(64'b01, 2);
  endtask

  task automatic test_check_verdicts();
    wait_drained();
    write_reg(CFG_POLY, 32'h1);
    write_reg(CFG_DEGREE, 32'd1);
    write_reg(CFG_MODE, 32'(MODE_CHECK));
    send_message(64'b11, 2);
    send_message(64'b10, 2);
    // x^2 + x: generator divisible by x
    wait_drained();
    write_reg(CFG_POLY, 32'h2);
    write_reg(CFG_DEGREE, 32'd2);
    send_message(64'b110, 3);
  endtask

  task automatic test_degree_limits();
    wait_drained();
    write_reg(CFG_MODE, 32'(MODE_GENERATE));
    write_reg(CFG_POLY, 32'hFFFF_FFFF);
    write_reg(CFG_DEGREE, 32'd0);
    send_message(64'b1, 1);
    wait_drained();
    write_reg(CFG_POLY, 32'h04C1_1DB7);
    write_reg(CFG_DEGREE, 32'd63);
    send_message(64'b1, 1);
    wait_drained();
    write_reg(CFG_POLY, 32'h0);
    write_reg(CFG_DEGREE, 32'd32);
    send_message(64'b01, 2);
  endtask

  task automatic test_midmessage_changes();
    wait_drained();
    write_reg(CFG_POLY, 32'h07);
    write_reg(CFG_DEGREE, 32'd8);
    write_reg(CFG_MODE, 32'(MODE_CHECK));
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b0);
    send_bit(1'b1, 1'b0);
    // partial remainder survives, masked to the narrower degree
    wait_drained();
    write_reg(CFG_DEGREE, 32'd4);
    send_bit(1'b1, 1'b0);
    send_bit(1'b1, 1'b1);
    wait_drained();
    write_reg(CFG_MODE, 32'(MODE_GENERATE));
    send_bit(1'b1, 1'b0);
    send_bit(1'b1, 1'b0);
    wait_drained();
    write_reg(CFG_MODE, 32'(MODE_CHECK));
    send_bit(1'b0, 1'b1);
  endtask

  task automatic test_receiver_holdoff();
    wait_drained();
    write_reg(CFG_POLY, 32'(POLY_RESET));
    write_reg(CFG_DEGREE, 32'(DEGREE_RESET));
    write_reg(CFG_MODE, 32'(MODE_GENERATE));
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_cycles = 300;
    send_message(64'hA5, 8);
    send_message(64'h3C, 6);
    send_message(64'h1, 2);
    // sender pauses until every result is out
    wait_drained();
    send_message(64'h5, 3);
  endtask

  task automatic test_random_traffic(int n_items, int snd_pct, int rcv_pct);
    logic [63:0] word;
    int len;
    int d;
    int sel;
    int start;
    start = bits_sent;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    while (bits_sent - start < n_items) begin
      if ($urandom_range(1)) begin
        wait_drained();
        sel = $urandom_range(3);
        write_reg(CFG_POLY, sel == 0 ? 32'h0 : sel == 1 ? 32'hFFFF_FFFF : $urandom());
        sel = $urandom_range(99);
        write_reg(CFG_DEGREE, sel < 60 ? $urandom_range(8, 1) :
                              sel < 85 ? $urandom_range(32, 9) :
                              sel < 92 ? 0 : $urandom_range(63, 33));
        write_reg(CFG_MODE, $urandom_range(1) ? 32'(MODE_CHECK) : 32'(MODE_GENERATE));
      end
      d = eff_degree(cfg_degree);
      sel = $urandom_range(99);
      if (cfg_mode == MODE_CHECK && sel < 70) begin
        len = $urandom_range(d > 12 ? 2 : 6, 1);
        word = multiple_of_generator({$urandom(), $urandom()}, len);
        len = len + d;
        if (sel < 15) word[$urandom_range(len - 1)] ^= 1'b1;
      end else begin
        len = $urandom_range(12, 1);
        word = {$urandom(), $urandom()};
      end
      send_message(word, len);
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_POLY;
    cfg_data <= '0;
    bits_ch.valid <= 1'b0;
    bits_ch.msg_bit <= 1'b0;
    bits_ch.last_bit <= 1'b0;
    cfg_poly = POLY_RESET;
    cfg_degree = DEGREE_RESET;
    cfg_mode = MODE_GENERATE;
    crc_rem = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_config();
    test_check_verdicts();
    test_degree_limits();
    test_midmessage_changes();
    test_receiver_holdoff();
    test_random_traffic(25, 0, 0);
    test_random_traffic(22, 74, 0);
    test_random_traffic(22, 0, 74);
    test_random_traffic(22, 16, 16);
    wait_drained();

    $display("tb: %0d bits in %0d messages, %0d results checked",
             bits_sent, messages_sent, results_checked);
    $display("tb: %0d check verdicts (%0d clean), degree limits, mid-message changes, hold-off",
             verdicts_seen, verdicts_ok);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
